[sv/lgs_pkg.sv]
// Shared types and constants for the linear gradient shader.
// Used by lgs_cmd_if and by linear_gradient_shader.
// No dependencies.
package lgs_pkg;

  // Item operation codes
  typedef enum logic {
    OP_SHADE = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Configuration register indexes (byte address 4*index)
  typedef enum logic [1:0] {
    REG_COEF_X      = 2'd0,
    REG_COEF_Y      = 2'd1,
    REG_COEF_OFFSET = 2'd2,
    REG_STOP_COUNT  = 2'd3
  } reg_idx_t;

  // One colour stop, unpremultiplied Q0.16 channels
  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } stop_t;

  localparam int CFG_AW     = 4;
  localparam int SLOT_W     = 4;
  localparam int CHAN_W     = 16;
  localparam int STOP_CNT_W = 5;

  // Gradient position is held in Q.17 (twice the Q16.16 scale)
  localparam int          FRAC_BITS = 17;
  localparam int          POS_W     = FRAC_BITS + 1;
  localparam logic [17:0] ONE_Q17   = 18'h20000;
  localparam logic [17:0] HALF_Q17  = 18'h10000;

  // Rounded divide constants for the 8-bit conversion
  localparam logic [16:0] ALPHA_DIV  = 17'd131070;
  localparam logic [24:0] ALPHA_BIAS = 25'd65535;
  localparam logic [32:0] COL_DIV    = 33'd8589672450;
  localparam logic [40:0] COL_BIAS   = 41'd4294836225;

endpackage

[sv/lgs_cmd_if.sv]
// Input channel of the gradient shader: shade and stop-write items.
// Depends on lgs_pkg.
interface lgs_cmd_if #(
  parameter int COORD_BITS = 12
);
  import lgs_pkg::*;

  logic                  valid;
  logic                  ready;
  op_t                   operation;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  span_last;
  logic [SLOT_W-1:0]     stop_index;
  logic [CHAN_W-1:0]     stop_alpha;
  logic [CHAN_W-1:0]     stop_red;
  logic [CHAN_W-1:0]     stop_green;
  logic [CHAN_W-1:0]     stop_blue;

  modport source (
    output valid, operation, pixel_x, pixel_y, span_last,
           stop_index, stop_alpha, stop_red, stop_green, stop_blue,
    input  ready
  );

  modport sink (
    input  valid, operation, pixel_x, pixel_y, span_last,
           stop_index, stop_alpha, stop_red, stop_green, stop_blue,
    output ready
  );

endinterface

[sv/lgs_pix_if.sv]
// Output channel of the gradient shader: one packed ARGB pixel per item.
// No dependencies.
interface lgs_pix_if;

  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  logic        last;

  modport source (
    output valid, pixel_argb, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_argb, last,
    output ready
  );

endinterface

[sv/linear_gradient_shader.sv]
// Linear gradient shader, eight register stages. A shade item's pixel is valid on
// the output when it reaches stage eight; one item enters every clock unless a stall
// reaches stage one, and a stalled output holds the full stages behind it up to a gap.
// Stop writes travel the same pipeline and update the stop memory in stage four,
// the stage where shade items read it, so item order is kept; they give no pixel.
// Reset (rst, synchronous) empties the pipeline and restores the registers;
// the stop memory is not cleared and holds garbage until written.
module linear_gradient_shader #(
  parameter int MAX_STOPS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lgs_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  lgs_cmd_if.sink                     cmd,
  lgs_pix_if.source                   pix
);
  import lgs_pkg::*;

  localparam int AW  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int XW  = COORD_BITS + 2;          // signed 2x+1
  localparam int PW  = 32 + XW;                 // coefficient product
  localparam int SW  = PW + 2;                  // sum of three terms
  localparam int PRW = POS_W + STOP_CNT_W;      // scaled position

  // Linear blend of two Q0.16 channels with a Q.17 weight, rounded
  function automatic logic [15:0] blend(input logic [15:0] v0,
                                        input logic [15:0] v1,
                                        input logic [16:0] w);
    logic [17:0] wc;
    logic [33:0] acc;
    wc  = ONE_Q17 - 18'(w);
    acc = 34'(v0) * 34'(wc) + 34'(v1) * 34'(w) + 34'(HALF_Q17);
    return acc[32:17];
  endfunction

  // Quotient by 131070; the shift estimate is at most one short
  function automatic logic [7:0] alpha_byte(input logic [24:0] y);
    logic [7:0]  q0;
    logic [24:0] thr;
    q0  = y[24:17];
    thr = 25'(9'(q0) + 9'd1) * 25'(ALPHA_DIV);
    return q0 + {7'd0, (y >= thr)};
  endfunction

  // Quotient by 2*65535^2; the shift estimate is at most one short
  function automatic logic [7:0] col_byte(input logic [40:0] y);
    logic [7:0]  q0;
    logic [41:0] thr;
    q0  = y[40:33];
    thr = 42'(9'(q0) + 9'd1) * 42'(COL_DIV);
    return q0 + {7'd0, (42'(y) >= thr)};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0]      coef_x;
  logic signed [31:0]      coef_y;
  logic signed [31:0]      coef_offset;
  logic [STOP_CNT_W-1:0]   stop_count;
  logic                    cfg_wr;
  logic [STOP_CNT_W-1:0]   nm1;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x      <= '0;
      coef_y      <= '0;
      coef_offset <= '0;
      stop_count  <= STOP_CNT_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_COEF_X:      coef_x      <= pwdata;
        REG_COEF_Y:      coef_y      <= pwdata;
        REG_COEF_OFFSET: coef_offset <= pwdata;
        REG_STOP_COUNT:  stop_count  <= pwdata[STOP_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_COEF_X:      prdata = coef_x;
      REG_COEF_Y:      prdata = coef_y;
      REG_COEF_OFFSET: prdata = coef_offset;
      REG_STOP_COUNT:  prdata = 32'(stop_count);
      default:         prdata = '0;
    endcase
  end

  // Stops in use minus one: zero counts as one, saturate at the memory depth
  always_comb begin
    if (stop_count == '0) begin
      nm1 = '0;
    end else if (32'(stop_count) > MAX_STOPS) begin
      nm1 = STOP_CNT_W'(MAX_STOPS - 1);
    end else begin
      nm1 = stop_count - STOP_CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage advances when empty or when the next one does
  // ---------------------------------------------------------------------------
  logic [8:1] vld;
  logic [8:1] adv;
  logic [8:1] lst;

  always_comb begin
    adv[8] = !vld[8] || pix.ready;
    for (int i = 7; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign cmd.ready = adv[1];

  // Stage payload
  logic signed [XW-1:0]  odd_x;
  logic signed [XW-1:0]  odd_y;
  logic signed [PW-1:0]  prod_x1;
  logic signed [PW-1:0]  prod_y1;
  logic signed [32:0]    off1;
  op_t                   op1, op2, op3;
  stop_t                 stop1, stop2, stop3;
  logic [SLOT_W-1:0]     slot1, slot2, slot3;
  logic signed [SW-1:0]  sum2;
  logic [POS_W-1:0]      t_clamp;
  logic [PRW-1:0]        p3;
  logic [AW-1:0]         idx3;
  logic [AW-1:0]         idx3_nx;
  logic                  slot_ok;
  stop_t                 stop_mem [MAX_STOPS];
  stop_t                 rd0, rd1;
  logic [FRAC_BITS-1:0]  w4;
  logic [15:0]           a5;
  logic [2:0][15:0]      c5;
  logic [24:0]           ya6;
  logic [2:0][31:0]      x6;
  logic [7:0]            a7;
  logic [2:0][40:0]      y7;
  logic [31:0]           argb8;

  assign odd_x = signed'({1'b0, cmd.pixel_x[COORD_BITS-1:0], 1'b1});
  assign odd_y = signed'({1'b0, cmd.pixel_y[COORD_BITS-1:0], 1'b1});

  // Clamp the position to [0, 1]
  always_comb begin
    if (sum2[SW-1]) begin
      t_clamp = '0;
    end else if (sum2 > SW'(ONE_Q17)) begin
      t_clamp = ONE_Q17;
    end else begin
      t_clamp = sum2[POS_W-1:0];
    end
  end

  assign idx3    = AW'(p3[PRW-1:FRAC_BITS]);
  assign idx3_nx = idx3 + AW'(1);
  assign slot_ok = 32'(slot3) < MAX_STOPS;

  // Advance the valid bits; stop writes leave the pipeline at stage four
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= cmd.valid;
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3] && (op3 == OP_SHADE);
      if (adv[5]) vld[5] <= vld[4];
      if (adv[6]) vld[6] <= vld[5];
      if (adv[7]) vld[7] <= vld[6];
      if (adv[8]) vld[8] <= vld[7];
    end
  end

  // Carry the span marker alongside
  always_ff @(posedge clk) begin
    if (adv[1]) lst[1] <= cmd.span_last;
    for (int i = 2; i <= 8; i++) begin
      if (adv[i]) lst[i] <= lst[i-1];
    end
  end

  // Stages one to three: products, sum, clamp and scale by stop span
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod_x1 <= PW'(coef_x) * PW'(odd_x);
      prod_y1 <= PW'(coef_y) * PW'(odd_y);
      off1    <= signed'({coef_offset, 1'b0});
      op1     <= cmd.operation;
      slot1   <= cmd.stop_index;
      stop1   <= {cmd.stop_alpha, cmd.stop_red, cmd.stop_green, cmd.stop_blue};
    end
    if (adv[2]) begin
      sum2  <= SW'(prod_x1) + SW'(prod_y1) + SW'(off1);
      op2   <= op1;
      slot2 <= slot1;
      stop2 <= stop1;
    end
    if (adv[3]) begin
      p3    <= PRW'(t_clamp) * PRW'(nm1);
      op3   <= op2;
      slot3 <= slot2;
      stop3 <= stop2;
    end
  end

  // Stage four: stop memory, written by stop items and read by shade items;
  // on an exact stop position read the same stop twice
  always_ff @(posedge clk) begin
    if (adv[4] && vld[3]) begin
      if (op3 == OP_WRITE) begin
        if (slot_ok) stop_mem[AW'(slot3)] <= stop3;
      end else begin
        rd0 <= stop_mem[idx3];
        rd1 <= stop_mem[(p3[FRAC_BITS-1:0] != '0) ? idx3_nx : idx3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) w4 <= p3[FRAC_BITS-1:0];
  end

  // Stages five to eight: blend, premultiply, convert to bytes
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      a5    <= blend(rd0.alpha, rd1.alpha, w4);
      c5[0] <= blend(rd0.red,   rd1.red,   w4);
      c5[1] <= blend(rd0.green, rd1.green, w4);
      c5[2] <= blend(rd0.blue,  rd1.blue,  w4);
    end
    if (adv[6]) begin
      ya6 <= (25'(a5) << 9) - (25'(a5) << 1) + ALPHA_BIAS;
      for (int k = 0; k < 3; k++) begin
        x6[k] <= 32'(a5) * 32'(c5[k]);
      end
    end
    if (adv[7]) begin
      a7 <= alpha_byte(ya6);
      for (int k = 0; k < 3; k++) begin
        y7[k] <= (41'(x6[k]) << 9) - (41'(x6[k]) << 1) + COL_BIAS;
      end
    end
    if (adv[8]) begin
      argb8 <= {a7, col_byte(y7[0]), col_byte(y7[1]), col_byte(y7[2])};
    end
  end

  assign pix.valid      = vld[8];
  assign pix.pixel_argb = argb8;
  assign pix.last       = lst[8];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("pipeline not empty after reset");

  a_take_into_bubble: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> cmd.ready)
    else $error("empty first stage refuses an item");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !adv[4] |=> vld[3] && $stable(p3))
    else $error("stalled stage three lost its item");

  a_write_no_pixel: assert property (@(posedge clk) disable iff (rst)
    vld[3] && (op3 == OP_WRITE) && adv[4] |=> !vld[4])
    else $error("stop write produced a pixel");

  a_premul_bound: assert property (@(posedge clk) disable iff (rst)
    vld[8] |-> (argb8[23:16] <= argb8[31:24]) && (argb8[15:8] <= argb8[31:24])
               && (argb8[7:0] <= argb8[31:24]))
    else $error("premultiplied colour exceeds alpha");

endmodule
